/* hdl/divider_timer_with_reload_defines.svh */
// assertion macros for the divider timer checker
// no dependencies; included by files that carry concurrent assertions
`ifndef DIVIDER_TIMER_WITH_RELOAD_DEFINES_SVH
`define DIVIDER_TIMER_WITH_RELOAD_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define DTR_ASSERT_NOW(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define DTR_ASSERT_NEXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dtr_pkg.sv */
// shared types, codes and helpers for the divider timer
// no dependencies
package dtr_pkg;

  // operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register addresses
  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA = 16'hFF05;
  localparam logic [15:0] ADDR_TMA  = 16'hFF06;
  localparam logic [15:0] ADDR_TAC  = 16'hFF07;

  localparam logic [4:0] TAC_HIGH_ONES = 5'b11111;
  localparam logic [7:0] OPEN_READ     = 8'hFF;
  localparam int         SOUND_BIT     = 12;
  localparam int         TAC_ON_BIT    = 2;

  // input word
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [7:0]  tick_cycles;
  } dtr_in_t;

  // result word
  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_interrupt;
    logic       sound_pulse;
  } dtr_out_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RUN
  } dtr_state_t;

  // status from the shared step unit
  typedef struct packed {
    logic [15:0] counter_inc;
    logic        sel_fall;
    logic        snd_fall;
    logic        sel_level;
    logic [7:0]  tima_inc;
    logic        tima_wrap;
  } dtr_step_t;

  // level of the counter bit that the clock select picks
  function automatic logic sel_level(input logic [15:0] cnt, input logic [1:0] sel);
    logic lvl;
    case (sel)
      2'd0:    lvl = cnt[9];
      2'd1:    lvl = cnt[3];
      2'd2:    lvl = cnt[5];
      default: lvl = cnt[7];
    endcase
    return lvl;
  endfunction

endpackage

/* hdl/dtr_step_unit.sv */
// shared step unit: counter increment, edge detect and timer count-once
// depends on dtr_pkg
module dtr_step_unit
  import dtr_pkg::*;
(
  input  logic [15:0] counter,
  input  logic [1:0]  clk_sel,
  input  logic [7:0]  tima,
  output dtr_step_t   step
);

  logic [15:0] inc;

  // one count of the system counter
  assign inc = counter + 16'd1;

  // falling edges across that count
  always_comb begin
    step.counter_inc = inc;
    step.sel_level   = sel_level(counter, clk_sel);
    step.sel_fall    = step.sel_level && !sel_level(inc, clk_sel);
    step.snd_fall    = counter[SOUND_BIT] && !inc[SOUND_BIT];
    step.tima_inc    = tima + 8'd1;
    step.tima_wrap   = (tima == 8'hFF);
  end

endmodule

/* hdl/divider_timer_with_reload.sv */
// Divider/timer with reload. One item is taken at a time: a bus read or write
// goes through ST_EXEC, a tick through ST_RUN, where the system counter is
// stepped one count per clock through the shared step unit for tick_cycles
// counts; each then registers its result. A result that waits in the output
// register holds while out_stall is high; the next item is accepted while it
// waits. A pending overflow reload is done at tick acceptance. No clearing pass.
// depends on dtr_pkg and dtr_step_unit
module divider_timer_with_reload
  import dtr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dtr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dtr_out_t out_data
);

  dtr_state_t state_r, state_nxt;

  logic [15:0] counter_r, counter_nxt;
  logic [7:0]  tima_r, tima_nxt;
  logic [7:0]  tma_r, tma_nxt;
  logic [2:0]  tac_r, tac_nxt;
  logic        pend_r, pend_nxt;

  dtr_in_t     req_r, req_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        irq_r, irq_nxt;
  logic        pulse_r, pulse_nxt;

  logic        out_valid_r, out_valid_nxt;
  dtr_out_t    out_data_r, out_data_nxt;

  logic        in_accept;
  logic        out_free;
  logic        count_en;
  logic [2:0]  new_tac;
  dtr_step_t   step;

  dtr_step_unit u_step (
    .counter (counter_r),
    .clk_sel (tac_r[1:0]),
    .tima    (tima_r),
    .step    (step)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign new_tac   = req_r.write_data[2:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_data.op == OP_TICK) ? ST_RUN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (cnt_r == 8'd0 && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    counter_nxt   = counter_r;
    tima_nxt      = tima_r;
    tma_nxt       = tma_r;
    tac_nxt       = tac_r;
    pend_nxt      = pend_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    irq_nxt       = irq_r;
    pulse_nxt     = pulse_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    count_en      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          req_nxt   = in_data;
          cnt_nxt   = in_data.tick_cycles;
          irq_nxt   = 1'b0;
          pulse_nxt = 1'b0;
          // pending reload at the start of a tick
          if (in_data.op == OP_TICK && pend_r) begin
            tima_nxt = tma_r;
            pend_nxt = 1'b0;
            irq_nxt  = 1'b1;
          end
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (req_r.op == OP_READ) begin
            case (req_r.bus_address)
              ADDR_DIV:  out_data_nxt.read_data = counter_r[15:8];
              ADDR_TIMA: out_data_nxt.read_data = tima_r;
              ADDR_TMA:  out_data_nxt.read_data = tma_r;
              ADDR_TAC:  out_data_nxt.read_data = {TAC_HIGH_ONES, tac_r};
              default:   out_data_nxt.read_data = OPEN_READ;
            endcase
          end else if (req_r.op == OP_WRITE) begin
            case (req_r.bus_address)
              ADDR_DIV: begin
                // counter reset can drop the selected bit and bit 12
                count_en = tac_r[TAC_ON_BIT] && step.sel_level;
                out_data_nxt.sound_pulse = counter_r[SOUND_BIT];
                counter_nxt = '0;
              end
              ADDR_TIMA: begin
                tima_nxt = req_r.write_data;
                pend_nxt = 1'b0;
              end
              ADDR_TMA: begin
                tma_nxt = req_r.write_data;
              end
              ADDR_TAC: begin
                // falling edge of the gated timer clock on a control change
                count_en = tac_r[TAC_ON_BIT] && step.sel_level &&
                           (!new_tac[TAC_ON_BIT] ||
                            !sel_level(counter_r, new_tac[1:0]));
                tac_nxt = new_tac;
              end
              default: ;
            endcase
          end
        end
      end
      ST_RUN: begin
        if (cnt_r != 8'd0) begin
          // one count per cycle
          counter_nxt = step.counter_inc;
          cnt_nxt     = cnt_r - 8'd1;
          if (step.snd_fall) begin
            pulse_nxt = 1'b1;
          end
          count_en = tac_r[TAC_ON_BIT] && step.sel_fall;
        end else if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.read_data       = '0;
          out_data_nxt.timer_interrupt = irq_r;
          out_data_nxt.sound_pulse     = pulse_r;
        end
      end
      default: ;
    endcase

    // timer count, overflow wraps to zero and waits for reload
    if (count_en) begin
      tima_nxt = step.tima_inc;
      if (step.tima_wrap) begin
        pend_nxt = 1'b1;
      end
    end
  end

  // control and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      counter_r   <= '0;
      tima_r      <= '0;
      tma_r       <= '0;
      tac_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      counter_r   <= counter_nxt;
      tima_r      <= tima_nxt;
      tma_r       <= tma_nxt;
      tac_r       <= tac_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cnt_r      <= cnt_nxt;
    irq_r      <= irq_nxt;
    pulse_r    <= pulse_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* hdl/dtr_checker.sv */
// port-level checker for the divider timer, bound to the top level
// depends on dtr_pkg and divider_timer_with_reload_defines.svh
`include "divider_timer_with_reload_defines.svh"

module dtr_checker
  import dtr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input dtr_out_t out_data
);

  // stalled result word holds
  `DTR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // one item at a time: busy straight after acceptance
  `DTR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted a word without going busy")

  // interrupt only comes with a tick, which reads as zero
  `DTR_ASSERT_NOW(a_irq_no_data, out_valid && out_data.timer_interrupt, out_data.read_data == 8'h00, "interrupt with read data")

  // read results carry no sound pulse
  `DTR_ASSERT_NOW(a_read_no_pulse, out_valid && out_data.read_data != 8'h00, !out_data.sound_pulse, "sound pulse on a read")

endmodule

bind divider_timer_with_reload dtr_checker u_dtr_checker (.*);
